// ----- hdl/xyr_pkg.sv -----
// Package for the XY-route round-robin switch allocator.
// Holds sizes, port and class codes, and the request and result types.
// No dependencies.
package xyr_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int COORD_BITS  = 4;
  localparam int CREDIT_BITS = 4;

  localparam int NUM_PORTS  = 5;
  localparam int PORT_BITS  = 3;
  localparam int CLASS_BITS = 2;

  typedef logic [PORT_BITS-1:0]  port_idx_t;
  typedef logic [CLASS_BITS-1:0] msg_class_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  localparam port_idx_t PORT_HOME  = 3'd0;
  localparam port_idx_t PORT_UP    = 3'd1;
  localparam port_idx_t PORT_DOWN  = 3'd2;
  localparam port_idx_t PORT_LEFT  = 3'd3;
  localparam port_idx_t PORT_RIGHT = 3'd4;

  localparam msg_class_t CLASS_REQ  = 2'd0;
  localparam msg_class_t CLASS_RESP = 2'd1;

  localparam int REG_ROUTER_X = 0;
  localparam int REG_ROUTER_Y = 1;

  // Row e holds the mask of ingress ports that ask for egress port e.
  typedef logic [NUM_PORTS-1:0][NUM_PORTS-1:0] req_matrix_t;

  typedef struct packed {
    msg_class_t                         msg_class;
    logic [NUM_PORTS-1:0]               head_valid;
    logic [NUM_PORTS*COORD_BITS-1:0]    head_dest_x;
    logic [NUM_PORTS*COORD_BITS-1:0]    head_dest_y;
    logic [NUM_PORTS*CREDIT_BITS-1:0]   port_credit;
  } alloc_req_t;

  typedef struct packed {
    logic [NUM_PORTS-1:0]               grant_valid;
    logic [NUM_PORTS*PORT_BITS-1:0]     grant_source;
  } alloc_rsp_t;

endpackage

// ----- hdl/xyr_route.sv -----
// XY route decode: maps each valid ingress head to its egress port.
// Produces one request mask per egress port. Depends on xyr_pkg.
module xyr_route
  import xyr_pkg::*;
(
  input  coord_t                          router_x,
  input  coord_t                          router_y,
  input  logic [NUM_PORTS-1:0]            head_valid,
  input  logic [NUM_PORTS*COORD_BITS-1:0] head_dest_x,
  input  logic [NUM_PORTS*COORD_BITS-1:0] head_dest_y,
  output req_matrix_t                     req
);

  always_comb begin
    coord_t    dx;
    coord_t    dy;
    port_idx_t p;
    req = '0;
    for (int d = 0; d < NUM_PORTS; d++) begin
      dx = head_dest_x[d*COORD_BITS +: COORD_BITS];
      dy = head_dest_y[d*COORD_BITS +: COORD_BITS];
      if (dx < router_x) begin
        p = PORT_LEFT;
      end else if (dx > router_x) begin
        p = PORT_RIGHT;
      end else if (dy < router_y) begin
        p = PORT_UP;
      end else if (dy > router_y) begin
        p = PORT_DOWN;
      end else begin
        p = PORT_HOME;
      end
      if (head_valid[d]) begin
        req[p][d] = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/xyr_alloc.sv -----
// Round-robin grant logic with the per-class, per-port last-grant pointers.
// Checks egress credit and picks one ingress per egress. Depends on xyr_pkg.
module xyr_alloc
  import xyr_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  msg_class_t                       msg_class,
  input  req_matrix_t                      req,
  input  logic [NUM_PORTS*CREDIT_BITS-1:0] port_credit,
  output alloc_rsp_t                       rsp
);

  port_idx_t last_grant [NUM_CLASSES][NUM_PORTS];

  logic                 class_ok;
  msg_class_t           row;
  logic [NUM_PORTS-1:0] win;
  port_idx_t            pick [NUM_PORTS];

  assign class_ok = (msg_class < NUM_CLASSES);
  assign row      = class_ok ? msg_class : CLASS_REQ;

  always_comb begin
    logic [CREDIT_BITS-1:0] credit;
    logic                   ok;
    logic [PORT_BITS:0]     j;
    port_idx_t              last;
    win = '0;
    for (int e = 0; e < NUM_PORTS; e++) begin
      pick[e] = PORT_HOME;
      credit  = port_credit[e*CREDIT_BITS +: CREDIT_BITS];
      last    = last_grant[row][e];
      if (e == int'(PORT_HOME)) begin
        if (msg_class == CLASS_RESP) begin
          ok = 1'b1;
        end else if (msg_class == CLASS_REQ) begin
          ok = (credit > 1);
        end else begin
          ok = (credit != '0);
        end
      end else begin
        ok = (credit != '0);
      end
      ok = ok && class_ok;
      for (int i = 1; i <= NUM_PORTS; i++) begin
        j = {1'b0, last} + (PORT_BITS+1)'(i);
        if (j >= (PORT_BITS+1)'(NUM_PORTS)) begin
          j = j - (PORT_BITS+1)'(NUM_PORTS);
        end
        if (ok && !win[e] && req[e][j[PORT_BITS-1:0]]) begin
          win[e]  = 1'b1;
          pick[e] = j[PORT_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    rsp.grant_valid  = win;
    rsp.grant_source = '0;
    for (int e = 0; e < NUM_PORTS; e++) begin
      rsp.grant_source[e*PORT_BITS +: PORT_BITS] = pick[e];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int e = 0; e < NUM_PORTS; e++) begin
          last_grant[c][e] <= PORT_HOME;
        end
      end
    end else if (en) begin
      for (int e = 0; e < NUM_PORTS; e++) begin
        if (win[e]) begin
          last_grant[row][e] <= pick[e];
        end
      end
    end
  end

endmodule

// ----- hdl/xy_route_round_robin_arbiter_core.sv -----
// Top level of the XY-route round-robin switch allocator.
// Holds the APB registers and the request and result registers.
// Depends on xyr_pkg, xyr_route and xyr_alloc.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (alloc_req_t)
//   out      output     out_valid / out_ready  out_data (alloc_rsp_t)
//   apb      input      psel / penable         paddr, pwdata, prdata
//
// A request is registered on acceptance and its grants are computed from that
// register, then registered into the result register when the request advances.
// One request is accepted every cycle while results are taken.
// The last-grant pointers update in the cycle a result is registered, so the
// next request already sees them. Reset clears pointers and coordinates.
// A stalled result holds the result register, and the request register then
// holds its request; in_ready drops only when both are full.
module xy_route_round_robin_arbiter_core
  import xyr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  alloc_req_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output alloc_rsp_t  out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  coord_t      router_x;
  coord_t      router_y;
  logic        req_valid;
  alloc_req_t  req_data;
  logic        advance;
  req_matrix_t req;
  alloc_rsp_t  rsp;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      router_x <= '0;
      router_y <= '0;
    end else if (cfg_write) begin
      unique case (int'(paddr[2]))
        REG_ROUTER_X: router_x <= pwdata[COORD_BITS-1:0];
        REG_ROUTER_Y: router_y <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (int'(paddr[2]))
      REG_ROUTER_X: prdata[COORD_BITS-1:0] = router_x;
      REG_ROUTER_Y: prdata[COORD_BITS-1:0] = router_y;
      default: ;
    endcase
  end

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_data <= in_data;
    end
  end

  xyr_route u_route (
    .router_x    (router_x),
    .router_y    (router_y),
    .head_valid  (req_data.head_valid),
    .head_dest_x (req_data.head_dest_x),
    .head_dest_y (req_data.head_dest_y),
    .req         (req)
  );

  xyr_alloc u_alloc (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .msg_class     (req_data.msg_class),
    .req           (req),
    .port_credit   (req_data.port_credit),
    .rsp           (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rsp;
    end
  end

endmodule
